[sv/nts_pkg.sv]
// Shared types, constants and elaboration-time tables for the note tone synthesizer.
package nts_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_DEPTH     = 1024;
  localparam int SINE_ADDR_BITS = $clog2(SINE_DEPTH);
  localparam int INC_Q_BITS     = PHASE_BITS + 6;
  localparam int NOTES          = 12;
  localparam int NOTE_MAX       = 11;
  localparam int OCTAVE_MAX     = 9;
  localparam int COUNT_BITS     = 22;
  localparam int SAMPLE_BITS    = 16;

  // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [63:0] RATE_UHZ    = 64'd44100000000;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam logic [63:0] ONE_Q60     = 64'h1000000000000000;

  typedef enum logic {
    OP_START_NOTE = 1'b0,
    OP_TICK       = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [3:0]  note_index;
    logic [3:0]  octave;
    logic [15:0] duration_ms;
  } nts_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          note_active;
    logic                          last;
  } nts_out_t;

  typedef logic [63:0]                   uhz_tab_t  [NOTES];
  typedef logic [INC_Q_BITS-1:0]         inc_tab_t  [NOTES];
  typedef logic signed [SAMPLE_BITS-1:0] sine_tab_t [SINE_DEPTH];

  // Octave-4 note frequencies in micro-hertz, C to B
  localparam uhz_tab_t OCT4_UHZ = '{
    64'd261625565, 64'd277182631, 64'd293664768, 64'd311126984,
    64'd329627557, 64'd349228231, 64'd369994423, 64'd391995436,
    64'd415304698, 64'd440000000, 64'd466163762, 64'd493883301
  };

  // floor(F * 2^INC_Q_BITS / rate) per note: the top-octave quotient with one
  // guard bit; lower octaves shift it down before rounding.
  function automatic inc_tab_t build_inc_tab();
    inc_tab_t    tab;
    logic [63:0] r;
    logic [63:0] q;
    for (int i = 0; i < NOTES; i++) begin
      r = OCT4_UHZ[i];
      q = '0;
      for (int j = 0; j < INC_Q_BITS; j++) begin
        r = {r[62:0], 1'b0};
        q = {q[62:0], 1'b0};
        if (r >= RATE_UHZ) begin
          r    = r - RATE_UHZ;
          q[0] = 1'b1;
        end
      end
      tab[i] = q[INC_Q_BITS-1:0];
    end
    return tab;
  endfunction

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Unsigned shift-and-subtract quotient, one bit per step
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series for sin (odd) or cos (even) in Q60
  function automatic logic [63:0] trig_q60(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] div;
    x2   = mul_q60(x, x);
    term = odd ? x : ONE_Q60;
    sum  = term;
    n    = odd ? 64'd1 : 64'd0;
    for (int k = 1; k < 30 && term != 64'd0; k++) begin
      div  = (n + 64'd1) * (n + 64'd2);
      term = div_u64(mul_q60(term, x2), div);
      n    = n + 64'd2;
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] v;
    logic [63:0] mag;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      quad = (64'd4 * 64'(i)) / SINE_DEPTH;
      rem  = 64'd4 * 64'(i) - quad * SINE_DEPTH;
      frac = (rem << 48) / SINE_DEPTH;
      x    = mul_q60(HALF_PI_Q60, frac << 12);
      v    = trig_q60(x, ~quad[0]);
      mag  = (v + (64'd1 << 45)) >> 46;
      tab[i] = (quad >= 64'd2) ? -SAMPLE_BITS'(mag) : SAMPLE_BITS'(mag);
    end
    return tab;
  endfunction

  localparam inc_tab_t  INC_TAB  = build_inc_tab();
  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[sv/note_tone_synthesizer.sv]
// Equal-tempered direct-digital-synthesis tone generator, top level.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries beats of two
//   kinds. A start-note beat loads the phase step for the semitone and octave,
//   clears the phase and loads the sample count floor(duration_ms * 44.1); it
//   produces no output beat. A tick beat produces exactly one output beat.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries the sine
//   sample, note_active and last; ticks after the note has run out give a
//   zero sample with note_active and last low.
//   A tick beat appears at the output in the cycle after it is taken.
//   Throughput: one beat per cycle while the output is not stalled; the work is
//   a table lookup and an add between the input handshake and the output register.
//   The sine table is a 1024-entry ROM read into the output register.
//   Stall: while the output register holds an untaken beat and the receiver
//   stalls, tick beats are held off; start-note beats are still taken, since
//   they produce nothing.
//   Reset: rst_ni clears phase, phase step and sample count, and empties the
//   output register; the block is ready in the first cycle after reset.
module note_tone_synthesizer
  import nts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  nts_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output nts_out_t out_data_o
);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] inc_q, inc_d;
  logic [COUNT_BITS-1:0] remain_q, remain_d;
  logic                  out_valid_q, out_valid_d;
  nts_out_t              out_q;

  logic                  out_blocked;
  logic                  in_acc;
  logic                  start_acc;
  logic                  tick_acc;
  logic                  sounding;

  logic [3:0]            idx_c;
  logic [3:0]            oct_c;
  logic [3:0]            shift_amt;
  logic [INC_Q_BITS-1:0] q_shift;
  logic [INC_Q_BITS:0]   inc_round;

  logic [32:0]           ms_prod;
  logic [COUNT_BITS-1:0] ms_x;
  logic [COUNT_BITS-1:0] count_c;

  logic [SINE_ADDR_BITS-1:0] sine_addr;

  // Handshake: only a tick needs room in the output register
  assign out_blocked = out_valid_q & out_stall_i;
  assign in_stall_o  = out_blocked & (in_data_i.opcode == OP_TICK);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign start_acc   = in_acc & (in_data_i.opcode == OP_START_NOTE);
  assign tick_acc    = in_acc & (in_data_i.opcode == OP_TICK);
  assign sounding    = (remain_q != '0);

  // Clamp out-of-range note and octave to B and octave nine
  assign idx_c = (in_data_i.note_index > 4'(NOTE_MAX)) ? 4'(NOTE_MAX) : in_data_i.note_index;
  assign oct_c = (in_data_i.octave > 4'(OCTAVE_MAX)) ? 4'(OCTAVE_MAX) : in_data_i.octave;

  // Phase step: shift the top-octave quotient down, then round half up
  assign shift_amt = 4'(OCTAVE_MAX) - oct_c;
  assign q_shift   = INC_TAB[idx_c] >> shift_amt;
  assign inc_round = {1'b0, q_shift} + {{INC_Q_BITS{1'b0}}, 1'b1};

  // Sample count = 44*ms + floor(ms/10), which equals floor(ms*441/10)
  assign ms_prod = {17'd0, in_data_i.duration_ms} * {16'd0, DIV10_MUL};
  assign ms_x    = COUNT_BITS'(in_data_i.duration_ms);
  assign count_c = (ms_x << 5) + (ms_x << 3) + (ms_x << 2)
                 + COUNT_BITS'(ms_prod[32:DIV10_SHIFT]);

  assign sine_addr = phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];

  always_comb begin
    phase_d  = phase_q;
    inc_d    = inc_q;
    remain_d = remain_q;
    if (start_acc) begin
      phase_d  = '0;
      inc_d    = inc_round[PHASE_BITS:1];
      remain_d = count_c;
    end else if (tick_acc && sounding) begin
      // advance the phase and count down the note
      phase_d  = phase_q + inc_q;
      remain_d = remain_q - COUNT_BITS'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (tick_acc) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      inc_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      inc_q       <= inc_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sine ROM read straight into the output register; hold while stalled
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      out_q.sample      <= sounding ? SINE_TAB[sine_addr] : '0;
      out_q.note_active <= sounding;
      out_q.last        <= (remain_q == COUNT_BITS'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.note_active) |-> (out_data_o.sample == '0 && !out_data_o.last))
    else $error("idle beat carries a sample or last flag");

  a_last_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last) |-> out_data_o.note_active)
    else $error("last flag on a beat outside a note");

  a_last_ends_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && remain_q == COUNT_BITS'(1)) |=> (remain_q == '0))
    else $error("note did not end after its final sample");

  a_start_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> (phase_q == '0))
    else $error("start note did not clear the phase");
`endif

endmodule
